/* hw/rtl/emh_pkg.sv */
// Package for the expiry min-heap core: sizes, operation and status codes.
// No dependencies.
package emh_pkg;
    localparam int HEAP_DEPTH = 256;
    localparam int KEY_COUNT  = 256;
    localparam int SW = $clog2(HEAP_DEPTH);      // slot index width
    localparam int CW = $clog2(HEAP_DEPTH + 1);  // count width
    localparam int KW = 8;
    localparam int EW = 32;

    localparam logic [2:0] OP_PUSH   = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_UPDATE = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_DUP    = 2'd3;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [EW-1:0] exp;
    } t_entry;
endpackage

/* hw/rtl/expiry_min_heap_core.sv */
// Top level of the expiry min-heap: sequencer over heap and key-position memories.
// Depends on emh_pkg and emh_ram.
//
// One operation at a time. busy rises the cycle after start is taken and stays
// high until the operation ends. The result strobe o_valid comes once, for one
// cycle, in the first cycle with busy low; the receiver cannot stall it.
// Timing is set by the single-read-port heap memory with registered read data:
// the key lookup reads the position memory; every sift level goes read parent,
// compare, finish swap (up) or read left, read right, compare, finish swap
// (down), with the two slot and two position writes of a swap spread over the
// compare state and S_SWP2; every operation ends by reading back the root. Key
// positions carry a valid bit per key in flip-flops, cleared at reset; heap
// slots need no clearing since only slots below the count are read.
module expiry_min_heap_core
    import emh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    i_kind,
    input  logic [KW-1:0] i_key_id,
    input  logic [EW-1:0] i_expiry_time,
    input  logic [EW-1:0] i_current_time,
    output logic          o_valid,
    output logic [1:0]    o_status,
    output logic [KW-1:0] o_out_key,
    output logic [EW-1:0] o_out_expiry,
    output logic [31:0]   o_remaining,
    output logic [CW-1:0] o_entry_count,
    output logic [KW-1:0] o_top_key,
    output logic [EW-1:0] o_top_expiry
);
    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LKW   = 5'd1;  // position read in flight
    localparam logic [4:0] S_LKD   = 5'd2;  // position data, dispatch
    localparam logic [4:0] S_SLW   = 5'd3;  // slot read in flight (remove/update/query)
    localparam logic [4:0] S_SLD   = 5'd4;
    localparam logic [4:0] S_LASTW = 5'd5;  // last slot read in flight
    localparam logic [4:0] S_LASTD = 5'd6;
    localparam logic [4:0] S_UPRD  = 5'd7;  // parent read issued
    localparam logic [4:0] S_UPCMP = 5'd8;
    localparam logic [4:0] S_DNL   = 5'd9;  // left child read issued
    localparam logic [4:0] S_DNR   = 5'd10; // left data, right read issued
    localparam logic [4:0] S_DNCMP = 5'd11;
    localparam logic [4:0] S_SWP2  = 5'd12; // second half of a swap write
    localparam logic [4:0] S_TOPW  = 5'd13;
    localparam logic [4:0] S_TOPD  = 5'd14;
    localparam logic [4:0] S_DONE  = 5'd15;
    localparam logic [4:0] S_ROOTW = 5'd16; // pop: root read in flight
    localparam logic [4:0] S_ROOTD = 5'd17;

    logic [4:0]    r_st, n_st;
    logic [2:0]    r_kind;
    logic [KW-1:0] r_key;
    logic [EW-1:0] r_exp, r_now;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [SW-1:0] r_i, n_i;          // current sift slot
    t_entry        r_cur, n_cur;      // entry travelling through the sift
    logic [SW-1:0] r_oth, n_oth;      // swap partner slot
    t_entry        r_le, n_le;        // left child data
    logic          r_down, n_down;    // S_SWP2 continues sifting down, not up
    logic          r_upafter, n_upafter;
    logic [1:0]    r_status, n_status;
    logic [KW-1:0] r_okey, n_okey;
    logic [EW-1:0] r_oexp, n_oexp;
    logic [31:0]   r_rem, n_rem;
    logic [KEY_COUNT-1:0] r_kv, n_kv;
    logic          r_valid, n_valid;
    logic [KW-1:0] r_tkey, n_tkey;
    logic [EW-1:0] r_texp, n_texp;

    // heap memory
    logic          h_we;
    logic [SW-1:0] h_wa, h_ra;
    t_entry        h_wd, h_rd;
    // position memory
    logic          p_we;
    logic [KW-1:0] p_wa, p_ra;
    logic [SW-1:0] p_wd, p_rd;

    emh_ram #(.DW($bits(t_entry)), .AW(SW)) u_heap (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_wa), .i_wdata(h_wd),
        .i_raddr(h_ra), .o_rdata(h_rd)
    );
    emh_ram #(.DW(SW), .AW(KW)) u_pos (
        .i_clk(i_clk), .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd),
        .i_raddr(p_ra), .o_rdata(p_rd)
    );

    logic [SW:0]   l_idx, r_idx;
    logic [SW-1:0] par_idx;
    logic          slot_ok;

    assign l_idx   = {r_i, 1'b1};
    assign r_idx   = {r_i, 1'b0} + (SW+1)'(2);
    assign par_idx = SW'((r_i - SW'(1)) >> 1);
    assign slot_ok = r_kv[r_key] && ({1'b0, p_rd} < r_cnt);

    always_comb begin
        logic [CW-1:0] last;
        logic signed [EW:0] d;
        logic          lt_l, rin, lin;
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_cur = r_cur; n_oth = r_oth;
        n_le = r_le; n_down = r_down; n_upafter = r_upafter;
        n_status = r_status; n_okey = r_okey; n_oexp = r_oexp; n_rem = r_rem;
        n_kv = r_kv; n_valid = 1'b0; n_tkey = r_tkey; n_texp = r_texp;
        h_we = 1'b0; h_wa = r_i; h_wd = r_cur; h_ra = r_i;
        p_we = 1'b0; p_wa = r_cur.key; p_wd = r_i; p_ra = r_key;
        last = r_cnt - CW'(1);
        d = $signed({1'b0, h_rd.exp}) - $signed({1'b0, r_now});
        lin = (l_idx < (SW+1)'(r_cnt));
        rin = (r_idx < (SW+1)'(r_cnt));
        lt_l = lin && (r_le.exp < r_cur.exp);
        unique case (r_st)
            S_IDLE: begin
                if (start) n_st = S_LKW;
            end
            S_LKW: n_st = S_LKD;
            S_LKD: begin
                n_status = ST_OK; n_okey = '0; n_oexp = '0; n_rem = '0;
                n_upafter = 1'b0;
                case (r_kind)
                    OP_PUSH: begin
                        if (slot_ok) begin
                            n_status = ST_DUP; n_st = S_TOPW;
                        end else if (r_cnt >= CW'(HEAP_DEPTH)) begin
                            n_status = ST_FULL; n_st = S_TOPW;
                        end else begin
                            n_kv[r_key] = 1'b1;
                            n_i = SW'(r_cnt);
                            n_cur = '{key: r_key, exp: r_exp};
                            n_cnt = r_cnt + CW'(1);
                            h_we = 1'b1; h_wa = SW'(r_cnt); h_wd = '{key: r_key, exp: r_exp};
                            p_we = 1'b1; p_wa = r_key; p_wd = SW'(r_cnt);
                            n_st = (r_cnt == '0) ? S_TOPW : S_UPRD;
                        end
                    end
                    OP_POP: begin
                        if (r_cnt == '0) begin
                            n_status = ST_ABSENT; n_st = S_TOPW;
                        end else begin
                            h_ra = '0; n_i = '0; n_st = S_ROOTW;
                        end
                    end
                    OP_REMOVE, OP_UPDATE, OP_QUERY: begin
                        if (!slot_ok) begin
                            n_status = ST_ABSENT;
                            if (r_kind == OP_QUERY) n_rem = '1;
                            n_st = S_TOPW;
                        end else begin
                            n_i = p_rd; h_ra = p_rd; n_st = S_SLW;
                        end
                    end
                    default: n_st = S_TOPW;
                endcase
            end
            S_ROOTW: begin h_ra = '0; n_st = S_ROOTD; end
            S_ROOTD: begin
                n_okey = h_rd.key; n_oexp = h_rd.exp;
                n_kv[h_rd.key] = 1'b0;
                n_cnt = last; n_i = '0;
                if (last == '0) n_st = S_TOPW;
                else begin h_ra = SW'(last); n_st = S_LASTW; end
            end
            S_SLW: n_st = S_SLD;
            S_SLD: begin
                case (r_kind)
                    OP_QUERY: begin
                        if (d > 33'sh07FFFFFFF) n_rem = 32'h7FFFFFFF;
                        else if (d < -33'sh080000000) n_rem = 32'h80000000;
                        else n_rem = d[31:0];
                        n_st = S_TOPW;
                    end
                    OP_UPDATE: begin
                        n_cur = '{key: h_rd.key, exp: r_exp};
                        h_we = 1'b1; h_wd = '{key: h_rd.key, exp: r_exp};
                        if (r_exp < h_rd.exp) n_st = S_UPRD;
                        else if (r_exp > h_rd.exp) n_st = S_DNL;
                        else n_st = S_TOPW;
                    end
                    default: begin // remove
                        n_kv[r_key] = 1'b0;
                        n_cnt = last;
                        if ({1'b0, r_i} < last) begin
                            h_ra = SW'(last); n_st = S_LASTW; n_upafter = 1'b1;
                        end else n_st = S_TOPW;
                    end
                endcase
            end
            // count already holds the index of the last slot here
            S_LASTW: begin h_ra = SW'(r_cnt); n_st = S_LASTD; end
            S_LASTD: begin
                n_cur = h_rd;
                h_we = 1'b1; h_wd = h_rd;
                p_we = 1'b1; p_wa = h_rd.key; p_wd = r_i;
                n_st = S_DNL;
            end
            S_UPRD: begin
                if (r_i == '0) n_st = S_TOPW;
                else begin h_ra = par_idx; n_oth = par_idx; n_st = S_UPCMP; end
            end
            S_UPCMP: begin
                if (r_cur.exp < h_rd.exp) begin
                    h_we = 1'b1; h_wd = h_rd;
                    p_we = 1'b1; p_wa = h_rd.key;
                    n_down = 1'b0; n_st = S_SWP2;
                end else n_st = S_TOPW;
            end
            S_DNL: begin
                h_ra = l_idx[SW-1:0];
                if (!lin) n_st = r_upafter ? S_UPRD : S_TOPW;
                else n_st = S_DNR;
            end
            S_DNR: begin
                n_le = h_rd; h_ra = r_idx[SW-1:0]; n_st = S_DNCMP;
            end
            S_DNCMP: begin
                if (rin && (h_rd.exp < (lt_l ? r_le.exp : r_cur.exp))) begin
                    n_oth = r_idx[SW-1:0];
                end else if (lt_l) begin
                    n_oth = l_idx[SW-1:0];
                end
                if ((rin && (h_rd.exp < (lt_l ? r_le.exp : r_cur.exp))) || lt_l) begin
                    h_we = 1'b1;
                    h_wd = (rin && (h_rd.exp < (lt_l ? r_le.exp : r_cur.exp))) ? h_rd : r_le;
                    p_we = 1'b1; p_wa = h_wd.key;
                    n_down = 1'b1; n_upafter = 1'b0; n_st = S_SWP2;
                end else n_st = r_upafter ? S_UPRD : S_TOPW;
            end
            S_SWP2: begin
                // move travelling entry into partner slot
                h_we = 1'b1; h_wa = r_oth; h_wd = r_cur;
                p_we = 1'b1; p_wa = r_cur.key; p_wd = r_oth;
                n_i = r_oth;
                n_st = r_down ? S_DNL : S_UPRD;
            end
            S_TOPW: begin h_ra = '0; n_st = S_TOPD; end
            S_TOPD: begin
                n_tkey = (r_cnt == '0) ? '0 : h_rd.key;
                n_texp = (r_cnt == '0) ? '0 : h_rd.exp;
                n_st = S_DONE;
            end
            S_DONE: begin n_valid = 1'b1; n_st = S_IDLE; end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_kv <= '0; r_valid <= 1'b0;
            r_down <= 1'b0; r_upafter <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_kv <= n_kv; r_valid <= n_valid;
            r_down <= n_down; r_upafter <= n_upafter;
        end
        if (r_st == S_IDLE && start) begin
            r_kind <= i_kind; r_key <= i_key_id;
            r_exp <= i_expiry_time; r_now <= i_current_time;
        end
        r_i <= n_i; r_cur <= n_cur; r_oth <= n_oth; r_le <= n_le;
        r_status <= n_status; r_okey <= n_okey; r_oexp <= n_oexp; r_rem <= n_rem;
        r_tkey <= n_tkey; r_texp <= n_texp;
    end

    assign busy          = (r_st != S_IDLE);
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_okey;
    assign o_out_expiry  = r_oexp;
    assign o_remaining   = r_rem;
    assign o_entry_count = r_cnt;
    assign o_top_key     = r_tkey;
    assign o_top_expiry  = r_texp;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(HEAP_DEPTH)) else $error("count over depth");
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid) else $error("result strobe held");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_st == S_IDLE) else $error("strobe outside idle");
    a_cnt_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |=> $stable(r_cnt)) else $error("count moved while idle");
`endif
endmodule

/* hw/rtl/emh_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module emh_ram #(
    parameter int DW = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
